// File: rtl/core/md5_pkg.sv
package md5_pkg;

	typedef logic [31:0] word_t;

	localparam word_t INIT_A = 32'h67452301;
	localparam word_t INIT_B = 32'hefcdab89;
	localparam word_t INIT_C = 32'h98badcfe;
	localparam word_t INIT_D = 32'h10325476;

	localparam word_t PAD_WORD = 32'h00000080;

	localparam word_t SINE_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// indexed by {stage, round[1:0]}
	localparam logic [4:0] ROT_TAB [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21
	};

	// message word used by a round
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] r;
		logic [3:0] g;
		r = rnd[3:0];
		case (rnd[5:4])
			2'd0:    g = r;
			2'd1:    g = 4'(r * 4'd5 + 4'd1);
			2'd2:    g = 4'(r * 4'd3 + 4'd5);
			default: g = 4'(r * 4'd7);
		endcase
		return g;
	endfunction

endpackage

// File: rtl/core/md5_message_digest.sv
// MD5 digest engine. Message words (first byte in bits 7:0) are taken one per
// transfer into a 16-word buffer; the word flagged last_word may carry 0..4
// valid bytes and closes the message. A full buffer is compressed by one
// shared round unit at one round per cycle, after which the result is folded
// into the chaining words. After the last word the block writes the padding
// and length words one per cycle, pausing while each full buffer is
// compressed, then presents the digest as four output transfers A, B, C, D
// and returns to the initial state.
// in_stall is high from the first cycle after a transfer that fills the
// buffer or ends the message until the engine is idle again.
module md5_message_digest (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         data_word,
	input  logic [2:0]          valid_bytes,
	input  logic                last_word,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         digest_word,
	output logic [1:0]          digest_index,
	output logic                last_digest
);
	import md5_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PAD  = 3'd1;
	localparam logic [2:0] S_COMP = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	localparam logic [1:0] PH_80   = 2'd0;
	localparam logic [1:0] PH_FILL = 2'd1;
	localparam logic [1:0] PH_HI   = 2'd2;

	logic [2:0]  state_q;
	logic [2:0]  ret_q;
	logic [1:0]  ph_q;
	logic [3:0]  pos_q;
	logic [5:0]  rnd_q;
	logic [63:0] len_q;
	logic [1:0]  oidx_q;
	word_t       chain_q [4];
	word_t       wv_q [4];

	logic        push_en;
	word_t       push_data;
	logic [2:0]  push_next;
	logic [1:0]  ph_next;
	word_t       last_data;
	logic        full_last;
	logic [3:0]  raddr;
	word_t       rdata;
	word_t       b_next;
	logic        in_xfer;
	logic        out_xfer;

	assign in_stall  = state_q != S_IDLE;
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = state_q == S_OUT;
	assign out_xfer  = out_valid && !out_stall;

	assign digest_word  = chain_q[oidx_q];
	assign digest_index = oidx_q;
	assign last_digest  = oidx_q == 2'd3;

	// counts above four are taken as four
	assign full_last = valid_bytes >= 3'd4;

	always_comb begin
		case (valid_bytes)
			3'd0:    last_data = PAD_WORD;
			3'd1:    last_data = {16'h0000, 8'h80, data_word[7:0]};
			3'd2:    last_data = {8'h00, 8'h80, data_word[15:0]};
			3'd3:    last_data = {8'h80, data_word[23:0]};
			default: last_data = data_word;
		endcase
	end

	always_comb begin
		push_en   = 1'b0;
		push_data = '0;
		push_next = state_q;
		ph_next   = ph_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					push_en = 1'b1;
					if (!last_word) begin
						push_data = data_word;
						push_next = S_IDLE;
					end else begin
						push_data = last_data;
						push_next = S_PAD;
						ph_next   = full_last ? PH_80 : PH_FILL;
					end
				end
			end
			S_PAD: begin
				push_en = 1'b1;
				case (ph_q)
					PH_80: begin
						push_data = PAD_WORD;
						ph_next   = PH_FILL;
					end
					PH_FILL: begin
						if (pos_q == 4'd14) begin
							push_data = len_q[31:0];
							ph_next   = PH_HI;
						end
					end
					default: begin
						push_data = len_q[63:32];
						push_next = S_OUT;
					end
				endcase
			end
			default: ;
		endcase
	end

	// prefetch the word for the next round; round 0 is fetched while loading
	assign raddr = (state_q == S_COMP) ? msg_index(6'(rnd_q + 6'd1)) : 4'd0;

	md5_msg_mem u_mem (
		.clk   (clk),
		.we    (push_en),
		.waddr (pos_q),
		.wdata (push_data),
		.raddr (raddr),
		.rdata (rdata)
	);

	md5_round u_round (
		.a      (wv_q[0]),
		.b      (wv_q[1]),
		.c      (wv_q[2]),
		.d      (wv_q[3]),
		.m      (rdata),
		.rnd    (rnd_q),
		.b_next (b_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			ph_q       <= PH_80;
			pos_q      <= '0;
			rnd_q      <= '0;
			len_q      <= '0;
			oidx_q     <= '0;
			chain_q[0] <= INIT_A;
			chain_q[1] <= INIT_B;
			chain_q[2] <= INIT_C;
			chain_q[3] <= INIT_D;
			for (int k = 0; k < 4; k++) begin
				wv_q[k] <= '0;
			end
		end else begin
			if (in_xfer) begin
				len_q <= last_word
					? len_q + {58'd0, (full_last ? 3'd4 : valid_bytes), 3'd0}
					: len_q + 64'd32;
			end
			if (push_en) begin
				pos_q <= pos_q + 4'd1;
				ph_q  <= ph_next;
				if (pos_q == 4'd15) begin
					state_q <= S_COMP;
					ret_q   <= push_next;
					rnd_q   <= '0;
					for (int k = 0; k < 4; k++) begin
						wv_q[k] <= chain_q[k];
					end
				end else begin
					state_q <= push_next;
				end
			end
			case (state_q)
				S_COMP: begin
					rnd_q   <= rnd_q + 6'd1;
					wv_q[0] <= wv_q[3];
					wv_q[1] <= b_next;
					wv_q[2] <= wv_q[1];
					wv_q[3] <= wv_q[2];
					if (rnd_q == 6'd63) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					for (int k = 0; k < 4; k++) begin
						chain_q[k] <= chain_q[k] + wv_q[k];
					end
					state_q <= ret_q;
				end
				S_OUT: begin
					if (out_xfer) begin
						oidx_q <= oidx_q + 2'd1;
						if (oidx_q == 2'd3) begin
							state_q    <= S_IDLE;
							pos_q      <= '0;
							len_q      <= '0;
							chain_q[0] <= INIT_A;
							chain_q[1] <= INIT_B;
							chain_q[2] <= INIT_C;
							chain_q[3] <= INIT_D;
							for (int k = 0; k < 4; k++) begin
								wv_q[k] <= '0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_no_input_during_digest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while digest pending");

	a_round_only_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q != 6'd0 |-> state_q == S_COMP)
		else $error("round counter running outside compression");

	a_full_block_compresses: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && pos_q == 4'd15) |=> (state_q == S_COMP && rnd_q == 6'd0))
		else $error("full block did not start compression");

	a_chain_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && last_digest) |=> (chain_q[0] == INIT_A && chain_q[3] == INIT_D
			&& pos_q == 4'd0 && len_q == 64'd0))
		else $error("chaining state not restored after digest");

endmodule

// File: rtl/core/md5_msg_mem.sv
module md5_msg_mem (
	input  logic                clk,
	input  logic                we,
	input  logic [3:0]          waddr,
	input  md5_pkg::word_t      wdata,
	input  logic [3:0]          raddr,
	output md5_pkg::word_t      rdata
);
	import md5_pkg::*;

	word_t mem_q [16];
	word_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

// File: rtl/core/md5_round.sv
module md5_round (
	input  md5_pkg::word_t a,
	input  md5_pkg::word_t b,
	input  md5_pkg::word_t c,
	input  md5_pkg::word_t d,
	input  md5_pkg::word_t m,
	input  logic [5:0]     rnd,
	output md5_pkg::word_t b_next
);
	import md5_pkg::*;

	word_t       f;
	word_t       sum;
	logic [4:0]  sh;
	logic [63:0] dbl;

	always_comb begin
		case (rnd[5:4])
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (b & d) | (c & ~d);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
	end

	assign sum    = a + f + m + SINE_TAB[rnd];
	assign sh     = ROT_TAB[{rnd[5:4], rnd[1:0]}];
	// rotate left: upper half of the doubled word shifted
	assign dbl    = {sum, sum} << sh;
	assign b_next = b + dbl[63:32];

endmodule

// File: dv/md5_digest_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the MD5 engine, keeps its own digest state and
// compares each digest word transfer against the oldest pending prediction.
module md5_digest_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  md5_pkg::word_t data_word,
	input  logic [2:0]    valid_bytes,
	input  logic          last_word,
	input  logic          out_valid,
	input  logic          out_stall,
	input  md5_pkg::word_t digest_word,
	input  logic [1:0]    digest_index,
	input  logic          last_digest,
	output int            fail_count,
	output int            outstanding
);

	import md5_pkg::word_t;

	localparam word_t CHAIN_INIT [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam word_t ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ROUND_SHIFT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	localparam word_t PAD_MARK    = 32'h00000080;
	localparam int    LENGTH_SLOT = 14;

	typedef struct packed {
		word_t      word;
		logic [1:0] index;
		logic       fin;
	} digest_t;

	digest_t     digest_exp[$];
	word_t       chain[4];
	word_t       msg_buf[16];
	int unsigned buf_pos;
	logic [63:0] msg_bits;

	task automatic restart_digest();
		for (int k = 0; k < 4; k++)
			chain[k] = CHAIN_INIT[k];
		buf_pos = 0;
		msg_bits = '0;
	endtask

	task automatic compress_block();
		word_t a, b, c, d, f, sum, hold;
		int g, s;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			sum = a + f + msg_buf[g] + ROUND_K[i];
			s = ROUND_SHIFT[(i / 16) * 4 + i % 4];
			hold = d;
			d = c;
			c = b;
			b = b + ((sum << s) | (sum >> (32 - s)));
			a = hold;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endtask

	task automatic absorb_word(input word_t w);
		msg_buf[buf_pos] = w;
		buf_pos = (buf_pos + 1) % 16;
		if (buf_pos == 0)
			compress_block();
	endtask

	task automatic take_word(input word_t w, input logic [2:0] vb, input logic lw);
		int unsigned n;
		word_t mask;
		if (!lw) begin
			// valid_bytes only matters on the closing word
			absorb_word(w);
			msg_bits += 64'd32;
			return;
		end
		n = (vb > 3'd4) ? 4 : vb;
		msg_bits += 64'(8 * n);
		if (n == 4) begin
			absorb_word(w);
			absorb_word(PAD_MARK);
		end else begin
			mask = (n == 0) ? '0 : ~(32'hffffffff << (8 * n));
			absorb_word((w & mask) | (PAD_MARK << (8 * n)));
		end
		while (buf_pos != LENGTH_SLOT)
			absorb_word('0);
		absorb_word(msg_bits[31:0]);
		absorb_word(msg_bits[63:32]);
		for (int k = 0; k < 4; k++)
			digest_exp.push_back('{word: chain[k], index: 2'(k), fin: (k == 3)});
		restart_digest();
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		digest_t want;
		if (!arst_n) begin
			restart_digest();
			digest_exp.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (in_valid && !in_stall)
				take_word(data_word, valid_bytes, last_word);
			if (out_valid && !out_stall) begin
				if (digest_exp.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected digest transfer: word %h index %0d last %0b",
							digest_word, digest_index, last_digest);
				end else begin
					want = digest_exp.pop_front();
					if (want.word !== digest_word || want.index !== digest_index ||
						want.fin !== last_digest) begin
						fail_count++;
						if (fail_count <= 10)
							$display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
								want.word, want.index, want.fin,
								digest_word, digest_index, last_digest);
					end
				end
			end
			outstanding = digest_exp.size();
		end
	end

endmodule

// File: dv/md5_message_digest_tb.sv
`timescale 1ns / 1ps

module md5_message_digest_tb;

	import md5_pkg::word_t;

	localparam int WORD_TARGET = 460;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HOLD, STALL_TOGGLE} stall_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	word_t      data_word = '0;
	logic [2:0] valid_bytes = '0;
	logic       last_word = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	word_t      digest_word;
	logic [1:0] digest_index;
	logic       last_digest;

	int fail_count;
	int outstanding;
	int burst_left = 0;
	int words_sent = 0;
	int stall_run = 0;
	stall_mode_t stall_mode = STALL_NONE;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	md5_message_digest dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_word    (data_word),
		.valid_bytes  (valid_bytes),
		.last_word    (last_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.last_digest  (last_digest)
	);

	md5_digest_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_word    (data_word),
		.valid_bytes  (valid_bytes),
		.last_word    (last_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digest_word  (digest_word),
		.digest_index (digest_index),
		.last_digest  (last_digest),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// receiver: runs of free flow, random stalls, solid holds and toggling
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_run = $urandom_range(4, 60);
		end
		stall_run--;
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
			STALL_HOLD:   out_stall <= 1'b1;
			default:      out_stall <= ~out_stall;
		endcase
	end

	task automatic send_word(input word_t w, input logic [2:0] vb, input logic lw);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		data_word <= w;
		valid_bytes <= vb;
		last_word <= lw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic send_message(input int nwords, input logic [2:0] last_vb);
		for (int i = 0; i < nwords - 1; i++)
			send_word($urandom, 3'($urandom), 1'b0);
		send_word($urandom, last_vb, 1'b1);
	endtask

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int pick;
		int len;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// empty message, junk above the count must be masked
		send_word(32'hffffffff, 3'd0, 1'b1);
		send_word(32'h00636261, 3'd3, 1'b1);
		send_word(32'hffffffff, 3'd4, 1'b1);
		send_word(32'hffffffff, 3'd1, 1'b1);
		send_word(32'h00000000, 3'd7, 1'b1);
		send_word(32'ha5a5a5a5, 3'd2, 1'b1);
		send_word(32'h5a5a5a5a, 3'd5, 1'b1);
		// 56 bytes: length no longer fits, padding spills into another block
		for (int i = 0; i < 13; i++)
			send_word((i % 2) ? 32'h00000000 : 32'hffffffff, 3'd7, 1'b0);
		send_word(32'h12345678, 3'd4, 1'b1);
		// zero-byte closing word after real data
		for (int i = 0; i < 3; i++)
			send_word($urandom, 3'($urandom), 1'b0);
		send_word($urandom, 3'd0, 1'b1);

		while (words_sent < WORD_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				len = $urandom_range(1, 12);
			else if (pick < 8)
				len = $urandom_range(13, 17) + 16 * $urandom_range(0, 1);
			else
				len = $urandom_range(18, 50);
			send_message(len, 3'($urandom_range(0, 7)));
		end
		in_valid <= 1'b0;

		@(posedge clk);
		wait (outstanding == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
